// ===== hw/rtl/luma_sobel_energy_assert.svh =====
// Assertion macros for the checker file of the Sobel energy block.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef LUMA_SOBEL_ENERGY_ASSERT_SVH
`define LUMA_SOBEL_ENERGY_ASSERT_SVH

// Checked at every rising edge outside reset.
`define LSE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define LSE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/lse_pkg.sv =====
// Shared constants and types of the luma Sobel energy block.
// No dependencies; used by lse_isqrt, the top level, the checker and the bench.
package lse_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;

  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CFG_DATA_W = 13;
  localparam int FW_RESET   = 640;
  localparam int FH_RESET   = 480;

  localparam int PIX_W      = 8;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  // Fixed-point luma weights for 0.3, 0.59 and 0.11, scaled by 256.
  localparam int LUMA_R = 77;
  localparam int LUMA_G = 151;
  localparam int LUMA_B = 28;

  localparam int GRAD_W     = 11;
  localparam int SQ_W       = 20;
  localparam int ENERGY_W   = 11;
  localparam int ENERGY_MAX = 1442;
  localparam int ROOT_W     = 11;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 3;

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic valid;
    logic last;
  } sq_tag_t;

  typedef struct packed {
    logic first_col;
    logic last_col;
    logic first_row;
    logic last_row;
    logic frame_last;
  } edge_flags_t;

  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } tap_col_t;

endpackage

// ===== hw/rtl/lse_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module lse_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 1024,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/lse_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, common stall enable.
// Depends on lse_pkg for widths and the tag type.
module lse_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  lse_pkg::sq_tag_t              in_tag,
  input  logic [lse_pkg::RAD_W-1:0]     in_rad,
  output lse_pkg::sq_tag_t              out_tag,
  output logic [lse_pkg::ROOT_W-1:0]    out_root
);

  localparam int STAGES = lse_pkg::ROOT_W;

  lse_pkg::sq_tag_t                 tag  [STAGES+1];
  logic [lse_pkg::RAD_W-1:0]        rad  [STAGES+1];
  logic [lse_pkg::REM_W-1:0]        rem  [STAGES+1];
  logic [lse_pkg::ROOT_W-1:0]       root [STAGES+1];

  assign tag[0]  = in_tag;
  assign rad[0]  = in_rad;
  assign rem[0]  = '0;
  assign root[0] = '0;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic [lse_pkg::REM_W-1:0]  rem_sh;
    logic [lse_pkg::REM_W-1:0]  trial;
    logic [lse_pkg::REM_W-1:0]  rem_next;
    logic [lse_pkg::ROOT_W-1:0] root_next;

    // Bring down the next two radicand bits and try 4*root+1.
    always_comb begin
      rem_sh = {rem[i][lse_pkg::REM_W-3:0], rad[i][lse_pkg::RAD_W-1 -: 2]};
      trial  = lse_pkg::REM_W'({root[i], 2'b01});
      if (rem_sh >= trial) begin
        rem_next  = rem_sh - trial;
        root_next = {root[i][lse_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_next  = rem_sh;
        root_next = {root[i][lse_pkg::ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        tag[i+1].valid <= 1'b0;
      end else if (en) begin
        tag[i+1].valid <= tag[i].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag[i+1].last <= tag[i].last;
        rad[i+1]      <= rad[i] << 2;
        rem[i+1]      <= rem_next;
        root[i+1]     <= root_next;
      end
    end
  end

  assign out_tag  = tag[STAGES];
  assign out_root = root[STAGES];

endmodule

// ===== hw/rtl/luma_sobel_energy.sv =====
// Top level of the luma Sobel energy block: luma, line-store RAM, window,
// gradients, squares, square root and output skid. Depends on lse_pkg, lse_ram, lse_isqrt.
//
//  channel   dir  handshake               payload
//  cfg       in   cfg_valid/cfg_ready     cfg_index, cfg_data
//  s_axis    in   s_axis_tvalid/tready    tdata = red, green, blue; tuser = kind
//  m_axis    out  m_axis_tvalid/tready    tdata = energy; tlast = frame_last
//
// One pixel per clock sustained while m_axis is not stalled: the line-store
// RAM is read once and written once per pixel, on separate ports, with a
// bypass for back-to-back hits. Each result passes stages 1 to 5, the isqrt
// stages and the output register, after the 3x3 window's one-row delay.
// Reset clears the counters, window and pipeline valids; the RAM is not cleared.
// A stall on m_axis fills the output skid entry, then s_axis_tready drops.
module luma_sobel_energy #(
  parameter int MAX_WIDTH = lse_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [0:0]                         cfg_index,
  input  logic [lse_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [lse_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // red, green, blue
  input  logic [0:0]                         s_axis_tuser,   // kind
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [lse_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // energy, zero pad
  output logic                               m_axis_tlast
);

  localparam int CLW  = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CW   = (WW > lse_pkg::FW_W) ? WW : lse_pkg::FW_W;
  localparam int XW   = WW + 1;
  localparam int FH_W = lse_pkg::FH_W;
  localparam int PW   = lse_pkg::PIX_W;

  // ---------------------------------------------------------------- config
  logic [lse_pkg::FW_W-1:0] frame_width;
  logic [FH_W-1:0]          frame_height;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= lse_pkg::FW_W'(lse_pkg::FW_RESET);
      frame_height <= FH_W'(lse_pkg::FH_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (lse_pkg::cfg_reg_e'(cfg_index))
        lse_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg_data[lse_pkg::FW_W-1:0];
        lse_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0]   fw_ext;
  logic [WW-1:0]   w_eff;
  logic [FH_W-1:0] h_eff;
  logic [FH_W-1:0] h_p1;

  always_comb begin
    fw_ext = CW'(frame_width);
    if (fw_ext == '0) begin
      w_eff = WW'(1);
    end else if (fw_ext > CW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_ext);
    end
    if (frame_height == '0) begin
      h_eff = FH_W'(1);
    end else if (frame_height > FH_W'(lse_pkg::MAX_HEIGHT)) begin
      h_eff = FH_W'(lse_pkg::MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
    h_p1 = h_eff + FH_W'(1);
  end

  // ---------------------------------------------------------------- stall
  logic en;
  logic skid_valid;
  logic acc;

  assign en            = !skid_valid;
  assign s_axis_tready = en && !rst;
  assign acc           = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------- stage 0
  logic [CLW-1:0]      in_col, in_col_next;
  logic [FH_W-1:0]     in_row, in_row_next;
  logic                drain, proceed, stale, early, shift, emit_a, emit_b;
  logic [CLW-1:0]      c0;
  logic [FH_W-1:0]     r0;
  logic [XW-1:0]       c_ext, c_p1, w_ext;
  lse_pkg::edge_flags_t flags0;
  logic [15:0]         luma_sum;
  logic [PW-1:0]       luma;

  always_comb begin
    luma_sum = 16'(lse_pkg::LUMA_R) * 16'(s_axis_tdata[7:0])
             + 16'(lse_pkg::LUMA_G) * 16'(s_axis_tdata[15:8])
             + 16'(lse_pkg::LUMA_B) * 16'(s_axis_tdata[23:16]);
    luma = luma_sum[15:8];
  end

  always_comb begin
    drain   = s_axis_tuser[0];
    proceed = 1'b0;
    stale   = 1'b0;
    r0      = in_row;
    c0      = in_col;
    if (!drain) begin
      proceed = 1'b1;
      // A pixel after the frame's last pixel opens a new frame.
      if (in_row >= h_eff) begin
        r0 = '0;
        c0 = '0;
      end
    end else if (in_row >= h_eff) begin
      if (in_row > h_p1 || (in_row == h_p1 && in_col != '0)) begin
        stale = 1'b1;
      end else begin
        proceed = 1'b1;
      end
    end

    c_ext  = XW'(c0);
    c_p1   = c_ext + XW'(1);
    w_ext  = XW'(w_eff);
    early  = proceed && drain && (r0 == h_p1);
    shift  = proceed && !early;
    emit_a = proceed && (c0 == '0) && (r0 >= FH_W'(2));
    emit_b = shift && (c0 != '0) && (r0 != '0);

    // The row-end output uses column w-1 of row r0-2; otherwise column c0-1
    // of row r0-1.
    if (emit_a) begin
      flags0.first_col  = (w_eff == WW'(1));
      flags0.last_col   = 1'b1;
      flags0.first_row  = (r0 == FH_W'(2));
      flags0.last_row   = (r0 >= h_p1);
      flags0.frame_last = (r0 == h_p1);
    end else begin
      flags0.first_col  = (c_ext == XW'(1));
      flags0.last_col   = (c_ext >= w_ext);
      flags0.first_row  = (r0 == FH_W'(1));
      flags0.last_row   = (r0 >= h_eff);
      flags0.frame_last = (r0 == h_eff) && (c_ext == w_ext);
    end

    in_col_next = in_col;
    in_row_next = in_row;
    if (acc) begin
      if (stale || early) begin
        in_col_next = '0;
        in_row_next = '0;
      end else if (proceed) begin
        if (c_p1 >= w_ext) begin
          in_col_next = '0;
          in_row_next = r0 + FH_W'(1);
        end else begin
          in_col_next = CLW'(c_p1);
          in_row_next = r0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col <= '0;
      in_row <= '0;
    end else begin
      in_col <= in_col_next;
      in_row <= in_row_next;
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic                 s1_valid, s1_shift, s1_write, s1_emit, s1_drain;
  logic [CLW-1:0]       s1_idx;
  logic [PW-1:0]        s1_luma;
  lse_pkg::edge_flags_t s1_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= acc && proceed;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_shift <= shift;
      s1_write <= shift && !drain;
      s1_emit  <= emit_a || emit_b;
      s1_drain <= drain;
      s1_idx   <= c0;
      s1_luma  <= luma;
      s1_flags <= flags0;
    end
  end

  // Line stores share one RAM entry: upper row in the high byte.
  logic [2*PW-1:0] ram_rdata, ram_wdata, fwd_data, rd;
  logic            ram_we, ram_re, fwd_hit;
  lse_pkg::tap_col_t new_col;

  assign ram_re    = acc && shift;
  assign ram_we    = en && s1_valid && s1_write;
  assign ram_wdata = {new_col.mid, s1_luma};

  lse_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_idx),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (c0),
    .rdata (ram_rdata)
  );

  // The RAM returns old data when a read meets the write of the previous
  // transaction at the same column, so that write is bypassed.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (en) begin
      fwd_hit <= ram_re && ram_we && (s1_idx == c0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fwd_data <= ram_wdata;
    end
  end

  lse_pkg::tap_col_t win0, win1, win2;
  lse_pkg::tap_col_t src0, src2;

  always_comb begin
    rd          = fwd_hit ? fwd_data : ram_rdata;
    new_col.top = rd[2*PW-1:PW];
    new_col.mid = rd[PW-1:0];
    new_col.bot = s1_drain ? rd[PW-1:0] : s1_luma;
    src0        = s1_flags.first_col ? win2 : win1;
    src2        = s1_flags.last_col ? win2 : new_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win0 <= '0;
      win1 <= '0;
      win2 <= '0;
    end else if (en && s1_valid && s1_shift) begin
      win0 <= win1;
      win1 <= win2;
      win2 <= new_col;
    end
  end

  function automatic lse_pkg::tap_col_t rep_rows(lse_pkg::tap_col_t s,
                                                 logic first_row,
                                                 logic last_row);
    lse_pkg::tap_col_t o;
    o.top = first_row ? s.mid : s.top;
    o.mid = s.mid;
    o.bot = last_row ? s.mid : s.bot;
    return o;
  endfunction

  // ---------------------------------------------------------------- stage 2
  lse_pkg::sq_tag_t  s2_tag, s3_tag, s4_tag, s5_tag;
  lse_pkg::tap_col_t s2_c0, s2_c1, s2_c2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_tag.valid <= 1'b0;
      s3_tag.valid <= 1'b0;
      s4_tag.valid <= 1'b0;
      s5_tag.valid <= 1'b0;
    end else if (en) begin
      s2_tag.valid <= s1_valid && s1_emit;
      s3_tag.valid <= s2_tag.valid;
      s4_tag.valid <= s3_tag.valid;
      s5_tag.valid <= s4_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_tag.last <= s1_flags.frame_last;
      s3_tag.last <= s2_tag.last;
      s4_tag.last <= s3_tag.last;
      s5_tag.last <= s4_tag.last;
      s2_c0 <= rep_rows(src0, s1_flags.first_row, s1_flags.last_row);
      s2_c1 <= rep_rows(win2, s1_flags.first_row, s1_flags.last_row);
      s2_c2 <= rep_rows(src2, s1_flags.first_row, s1_flags.last_row);
    end
  end

  function automatic logic [PW+1:0] wsum3(logic [PW-1:0] a, logic [PW-1:0] b,
                                          logic [PW-1:0] c);
    return (PW+2)'(a) + {1'b0, b, 1'b0} + (PW+2)'(c);
  endfunction

  // ---------------------------------------------------------------- stage 3
  logic signed [lse_pkg::GRAD_W-1:0] s3_gx, s3_gy;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_gx <= $signed({1'b0, wsum3(s2_c2.top, s2_c2.mid, s2_c2.bot)})
             - $signed({1'b0, wsum3(s2_c0.top, s2_c0.mid, s2_c0.bot)});
      s3_gy <= $signed({1'b0, wsum3(s2_c0.bot, s2_c1.bot, s2_c2.bot)})
             - $signed({1'b0, wsum3(s2_c0.top, s2_c1.top, s2_c2.top)});
    end
  end

  // ---------------------------------------------------------------- stage 4/5
  logic signed [2*lse_pkg::GRAD_W-1:0] sqx_full, sqy_full;
  logic [lse_pkg::SQ_W-1:0]            s4_sqx, s4_sqy;
  logic [lse_pkg::SQ_W:0]              s5_sum;

  assign sqx_full = s3_gx * s3_gx;
  assign sqy_full = s3_gy * s3_gy;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_sqx <= lse_pkg::SQ_W'(sqx_full);
      s4_sqy <= lse_pkg::SQ_W'(sqy_full);
      s5_sum <= (lse_pkg::SQ_W+1)'(s4_sqx) + (lse_pkg::SQ_W+1)'(s4_sqy);
    end
  end

  lse_pkg::sq_tag_t                 sq_tag;
  logic [lse_pkg::ROOT_W-1:0]       sq_root;

  lse_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_tag   (s5_tag),
    .in_rad   (lse_pkg::RAD_W'(s5_sum)),
    .out_tag  (sq_tag),
    .out_root (sq_root)
  );

  // ---------------------------------------------------------------- output
  logic                         push, out_free, out_valid, out_last, skid_last;
  logic [lse_pkg::ENERGY_W-1:0] out_energy, skid_energy;

  assign push     = en && sq_tag.valid;
  assign out_free = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_energy <= skid_energy;
        out_last   <= skid_last;
      end else begin
        out_energy <= lse_pkg::ENERGY_W'(sq_root);
        out_last   <= sq_tag.last;
      end
    end else if (push) begin
      skid_energy <= lse_pkg::ENERGY_W'(sq_root);
      skid_last   <= sq_tag.last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = lse_pkg::OUT_DATA_W'(out_energy);
  assign m_axis_tlast  = out_last;

endmodule

// ===== hw/rtl/lse_checker.sv =====
// Port-level checker for the luma Sobel energy block, bound to the top level.
// Depends on lse_pkg and luma_sobel_energy_assert.svh.
`include "luma_sobel_energy_assert.svh"

module lse_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [lse_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tlast
);

  // Energy never exceeds the largest Sobel magnitude and the pad stays zero.
  `LSE_ASSERT(a_energy_range, m_axis_tvalid |-> (m_axis_tdata <= lse_pkg::OUT_DATA_W'(lse_pkg::ENERGY_MAX)), "energy out of range")

  // A result that is not taken holds.
  `LSE_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

  // Input backpressure only follows an output stall.
  `LSE_ASSERT(a_ready_drop, $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready), "input stalled without output stall")

  // Nothing is offered right after reset.
  `LSE_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !m_axis_tvalid && !(s_axis_tvalid && rst && s_axis_tready), "result valid after reset")

endmodule

bind luma_sobel_energy lse_checker u_lse_checker (.*);

// ===== bench/tb.sv =====
// Self-checking bench for luma_sobel_energy: drives RGB frames and drain items,
// predicts each Sobel energy result and compares it with the m_axis output.
// Depends on lse_pkg and the luma_sobel_energy RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lse_pkg::*;

  localparam int LINE_DEPTH  = 1024;
  localparam int HEIGHT_CAP  = 4096;
  localparam int SETTLE      = 64;
  localparam int RANDOM_ITEMS = 800;

  typedef struct packed {
    logic [ENERGY_W-1:0] energy;
    logic                frame_last;
  } sobel_result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [0:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // red, green, blue
  logic [0:0]            s_axis_tuser;   // kind
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // energy, zero pad
  logic                  m_axis_tlast;   // frame_last

  luma_sobel_energy u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk = ~clk;

  // Predictor state.
  logic [FW_W-1:0]  width_reg;
  logic [FH_W-1:0]  height_reg;
  logic [7:0]       upper_line [LINE_DEPTH];
  logic [7:0]       lower_line [LINE_DEPTH];
  tap_col_t         window [3];
  int               luma_col;
  int               luma_row;
  sobel_result_t    energy_expected [$];

  int               err_count;
  int               items_sent;
  int               burst_left;
  bit               sender_gaps;
  int               sink_mode;
  int               hold_off_len;
  sobel_result_t    want;

  function automatic int eff_width();
    int w;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    return w;
  endfunction

  function automatic int eff_height();
    int h;
    h = height_reg;
    if (h < 1) h = 1;
    if (h > HEIGHT_CAP) h = HEIGHT_CAP;
    return h;
  endfunction

  function automatic int floor_root(int v);
    int res;
    int cand;
    res = 0;
    for (int b = 11; b >= 0; b--) begin
      cand = res | (1 << b);
      if (cand * cand <= v) res = cand;
    end
    return res;
  endfunction

  // Sobel magnitude at one output pixel; borders replicate the center taps.
  function automatic sobel_result_t sobel_at(tap_col_t lt, tap_col_t ct, tap_col_t rt,
                                             int orow, int oc, int w, int h);
    tap_col_t      src [3];
    int            top [3];
    int            mid [3];
    int            bot [3];
    int            gx;
    int            gy;
    sobel_result_t res;
    src[0] = (oc == 0) ? ct : lt;
    src[1] = ct;
    src[2] = (oc + 1 >= w) ? ct : rt;
    for (int k = 0; k < 3; k++) begin
      mid[k] = src[k].mid;
      top[k] = (orow == 0) ? mid[k] : int'(src[k].top);
      bot[k] = (orow + 1 >= h) ? mid[k] : int'(src[k].bot);
    end
    gx = (top[2] + 2 * mid[2] + bot[2]) - (top[0] + 2 * mid[0] + bot[0]);
    gy = (bot[0] + 2 * bot[1] + bot[2]) - (top[0] + 2 * top[1] + top[2]);
    res.energy     = floor_root(gx * gx + gy * gy);
    res.frame_last = (orow + 1 == h) && (oc + 1 == w);
    return res;
  endfunction

  task automatic predictor_reset();
    width_reg  = FW_W'(FW_RESET);
    height_reg = FH_W'(FH_RESET);
    for (int i = 0; i < LINE_DEPTH; i++) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
    for (int k = 0; k < 3; k++) window[k] = '0;
    luma_col = 0;
    luma_row = 0;
  endtask

  task automatic sobel_predict(input logic kind, input logic [23:0] rgb);
    int         w;
    int         h;
    int         row;
    int         col;
    int         idx;
    logic [7:0] luma;
    logic [7:0] top_b;
    logic [7:0] mid_b;
    w = eff_width();
    h = eff_height();
    luma = '0;
    if (!kind) begin
      luma = 8'((77 * int'(rgb[7:0]) + 151 * int'(rgb[15:8]) + 28 * int'(rgb[23:16])) >> 8);
      // A pixel after the frame's last pixel starts a new frame.
      if (luma_row >= h) begin
        luma_row = 0;
        luma_col = 0;
      end
    end else begin
      if (luma_row < h) return;
      if (luma_row > h + 1 || (luma_row == h + 1 && luma_col != 0)) begin
        luma_row = 0;
        luma_col = 0;
        return;
      end
    end
    row = luma_row;
    col = luma_col;
    idx = (col < LINE_DEPTH) ? col : LINE_DEPTH - 1;
    if (col == 0 && row >= 2)
      energy_expected.push_back(sobel_at(window[1], window[2], window[2], row - 2, w - 1, w, h));
    if (kind && row == h + 1) begin
      luma_row = 0;
      luma_col = 0;
      return;
    end
    top_b = upper_line[idx];
    mid_b = lower_line[idx];
    if (!kind) begin
      upper_line[idx] = mid_b;
      lower_line[idx] = luma;
    end
    window[0]     = window[1];
    window[1]     = window[2];
    window[2].top = top_b;
    window[2].mid = mid_b;
    window[2].bot = kind ? mid_b : luma;
    if (col >= 1 && row >= 1)
      energy_expected.push_back(sobel_at(window[0], window[1], window[2],
                                         row - 1, col - 1, w, h));
    if (col + 1 >= w) begin
      luma_col = 0;
      luma_row = row + 1;
    end else begin
      luma_col = col + 1;
    end
  endtask

  // Sends one item in bursts with random gaps; valid stays up between items.
  task automatic send_item(input logic kind, input logic [23:0] rgb);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = sender_gaps ? $urandom_range(6, 1) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rgb;
    s_axis_tuser  <= kind;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
    items_sent++;
    sobel_predict(kind, rgb);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (energy_expected.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_FRAME_WIDTH) width_reg = FW_W'(value);
    else height_reg = FH_W'(value);
    @(posedge clk);
  endtask

  task automatic configure(input int w, input int h);
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
  endtask

  // Pixel content: 0 random, 1 diagonal edge, 2 saturated palette, 3 black or white.
  function automatic logic [23:0] pixel_color(int mode, int row, int col, int w);
    logic [23:0] palette [6];
    logic [7:0]  v;
    palette[0] = 24'h000000;
    palette[1] = 24'hFFFFFF;
    palette[2] = 24'h0000FF;
    palette[3] = 24'h00FF00;
    palette[4] = 24'hFF0000;
    palette[5] = 24'h00FFFF;
    case (mode)
      1: begin
        v = (col > row) ? 8'hFF : 8'h00;
        return {v, v, v};
      end
      2: return palette[(row * w + col) % 6];
      3: begin
        v = $urandom_range(1, 0) ? 8'hFF : 8'h00;
        return {v, v, v};
      end
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_frame(input int mode, input int drains, input int noise_pct);
    int w;
    int h;
    w = eff_width();
    h = eff_height();
    for (int row = 0; row < h; row++) begin
      for (int col = 0; col < w; col++) begin
        // A drain item inside the frame must be ignored.
        if ($urandom_range(99, 0) < noise_pct) send_item(1'b1, 24'($urandom));
        send_item(1'b0, pixel_color(mode, row, col, w));
      end
    end
    repeat (drains) send_item(1'b1, 24'($urandom));
  endtask

  task automatic test_directed();
    configure(3, 3);
    send_item(1'b1, 24'hFFFFFF);
    send_frame(2, 4, 15);
    configure(4, 2);
    send_frame(1, 5, 0);
    send_item(1'b1, 24'h000000);
  endtask

  task automatic test_borders();
    configure(1, 1);
    send_frame(3, 2, 0);
    configure(1, 2);
    send_frame(0, 2, 0);
    configure(2, 1);
    send_frame(3, 3, 0);
    configure(3, 3);
    send_frame(0, 4, 0);
    configure(2, 5);
    send_frame(3, 3, 0);
    // New frames that start while the previous one is still draining.
    configure(4, 3);
    send_frame(0, 2, 0);
    send_frame(0, 0, 0);
    send_frame(0, 5, 0);
    // A height change leaves the position past the drain sequence.
    configure(4, 4);
    send_frame(0, 2, 0);
    configure(4, 1);
    send_item(1'b1, 24'($urandom));
    send_item(1'b1, 24'($urandom));
    send_frame(0, 5, 0);
  endtask

  task automatic test_register_range();
    configure(0, 3);
    send_frame(0, 2, 0);
    configure(8191, 1);
    send_frame(3, LINE_DEPTH + 1, 0);
    configure(1024, 2);
    send_frame(0, LINE_DEPTH + 1, 0);
    configure(3, 0);
    send_frame(0, 4, 0);
    configure(1, 8191);
    send_frame(0, 2, 0);
  endtask

  task automatic test_backpressure();
    configure(16, 6);
    sender_gaps = 1'b0;
    sink_mode = 0;
    hold_off_len = 400;
    send_frame(0, 17, 0);
    sender_gaps = 1'b1;
  endtask

  task automatic test_random();
    int  start;
    int  w;
    int  h;
    int  roll;
    int  mode;
    bit  clean;
    start = items_sent;
    clean = 1'b1;
    while (items_sent - start < RANDOM_ITEMS) begin
      sink_mode   = $urandom_range(2, 0);
      sender_gaps = ($urandom_range(3, 0) != 0);
      if (clean && $urandom_range(99, 0) < 40) begin
        roll = $urandom_range(99, 0);
        if (roll < 85) w = $urandom_range(12, 1);
        else if (roll < 95) w = $urandom_range(64, 13);
        else w = $urandom_range(2, 0);
        h = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(5, 1);
        configure(w, h);
      end
      w = eff_width();
      roll = $urandom_range(99, 0);
      mode = (roll < 70) ? 0 : (roll < 90) ? 3 : 2;
      roll = $urandom_range(99, 0);
      if (roll < 70) begin
        send_frame(mode, w + 1, $urandom_range(1, 0) * 10);
        clean = 1'b1;
      end else if (roll < 80) begin
        send_frame(mode, w + 1 + $urandom_range(3, 1), 0);
        clean = 1'b1;
      end else begin
        send_frame(mode, $urandom_range(w, 0), $urandom_range(1, 0) * 10);
        clean = 1'b0;
      end
    end
  endtask

  // Result sink with its own stall pattern and an occasional long hold-off.
  initial begin : sink
    int tick;
    tick = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_off_len != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_off_len - 1) @(posedge clk);
        hold_off_len = 0;
      end else begin
        case (sink_mode)
          1:       m_axis_tready <= ($urandom_range(99, 0) >= 30);
          2:       m_axis_tready <= ((tick % 11) >= 4);
          default: m_axis_tready <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (energy_expected.size() == 0) begin
        $error("unexpected result: energy %0d frame_last %0d",
               m_axis_tdata[ENERGY_W-1:0], m_axis_tlast);
        err_count++;
      end else begin
        want = energy_expected.pop_front();
        if (m_axis_tdata[ENERGY_W-1:0] !== want.energy) begin
          $error("energy: expected %0d, actual %0d", want.energy, m_axis_tdata[ENERGY_W-1:0]);
          err_count++;
        end
        if (m_axis_tlast !== want.frame_last) begin
          $error("frame_last: expected %0d, actual %0d", want.frame_last, m_axis_tlast);
          err_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #(20_000_000);
    $display("tb: done, errors");
    $finish;
  end

  initial begin : run
    int waited;
    err_count    = 0;
    items_sent   = 0;
    burst_left   = 0;
    sender_gaps  = 1'b1;
    sink_mode    = 0;
    hold_off_len = 0;
    predictor_reset();
    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_FRAME_WIDTH;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_borders();
    test_register_range();
    test_backpressure();
    test_random();

    s_axis_tvalid <= 1'b0;
    sink_mode = 0;
    waited = 0;
    while (energy_expected.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (energy_expected.size() != 0) begin
      $error("%0d expected results never arrived", energy_expected.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
